// ===== rtl/core/mdps_pkg.sv =====
// Shared types and constants of the split-accumulation modular dot product.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mdps_pkg;

   localparam int SPLIT_BITS = 56;
   localparam int MAX_TERMS  = 4096;

   localparam int ELEM_W    = 30;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int LOW_W     = 64;
   localparam int HIGH_W    = 40;
   localparam int GROUP_W   = 3;
   localparam int TERM_W    = $clog2(MAX_TERMS + 1);
   localparam int DIV_STEPS = LOW_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [LOW_W-1:0] LOW_MASK = (LOW_W'(1) << SPLIT_BITS) - LOW_W'(1);

   // Configuration register indexes.
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_POW2    = 1'b1;

   // Operand fed to the serial remainder unit, and where its remainder lands.
   typedef enum logic [1:0] {
      OPD_LOW,
      OPD_HIGH,
      OPD_POW,
      OPD_SUM
   } opd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACC,
      S_SPLIT,
      S_LD_LOW,
      S_DIV_LOW,
      S_LD_HIGH,
      S_DIV_HIGH,
      S_LD_POW,
      S_DIV_POW,
      S_MUL,
      S_LD_SUM,
      S_DIV_SUM,
      S_WAIT_OUT
   } state_type;

   typedef struct packed {
      logic    accept;    // take the input word, register its product
      logic    acc;       // add the product into the low accumulator
      logic    split;     // move the upper low bits into the high accumulator
      logic    mul_red;   // multiply the reduced power and high remainders
      logic    div_load;  // load an operand into the remainder unit
      logic    div_step;  // one bit of the remainder computation
      opd_type div_opd;
      logic    load_out;  // place the result in the output register, clear state
   } cmd_type;

   typedef struct packed {
      logic split_due;
      logic last;
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/mdps_ctrl.sv =====
// Controller state machine of the modular dot product.
// Depends on mdps_pkg; drives the datapath through a command struct.
`default_nettype none

module mdps_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire mdps_pkg::status_type status,
   output mdps_pkg::cmd_type        cmd
);

   mdps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdps_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mdps_pkg::S_IDLE: begin
            if (req_tvalid) state_in = mdps_pkg::S_ACC;
         end
         mdps_pkg::S_ACC: begin
            state_in = status.split_due ? mdps_pkg::S_SPLIT : mdps_pkg::S_IDLE;
         end
         mdps_pkg::S_SPLIT: begin
            state_in = status.last ? mdps_pkg::S_LD_LOW : mdps_pkg::S_IDLE;
         end
         mdps_pkg::S_LD_LOW:  state_in = mdps_pkg::S_DIV_LOW;
         mdps_pkg::S_DIV_LOW: begin
            if (status.div_last) state_in = mdps_pkg::S_LD_HIGH;
         end
         mdps_pkg::S_LD_HIGH:  state_in = mdps_pkg::S_DIV_HIGH;
         mdps_pkg::S_DIV_HIGH: begin
            if (status.div_last) state_in = mdps_pkg::S_LD_POW;
         end
         mdps_pkg::S_LD_POW:  state_in = mdps_pkg::S_DIV_POW;
         mdps_pkg::S_DIV_POW: begin
            if (status.div_last) state_in = mdps_pkg::S_MUL;
         end
         mdps_pkg::S_MUL:     state_in = mdps_pkg::S_LD_SUM;
         mdps_pkg::S_LD_SUM:  state_in = mdps_pkg::S_DIV_SUM;
         mdps_pkg::S_DIV_SUM: begin
            if (status.div_last) state_in = mdps_pkg::S_WAIT_OUT;
         end
         mdps_pkg::S_WAIT_OUT: begin
            if (!status.out_busy) state_in = mdps_pkg::S_IDLE;
         end
         default: state_in = mdps_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_opd = mdps_pkg::OPD_LOW;
      req_tready  = 1'b0;
      unique case (state_ff)
         mdps_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         mdps_pkg::S_ACC:   cmd.acc = 1'b1;
         mdps_pkg::S_SPLIT: cmd.split = 1'b1;
         mdps_pkg::S_LD_LOW: begin
            cmd.div_load = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_LOW;
         end
         mdps_pkg::S_DIV_LOW: begin
            cmd.div_step = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_LOW;
         end
         mdps_pkg::S_LD_HIGH: begin
            cmd.div_load = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_HIGH;
         end
         mdps_pkg::S_DIV_HIGH: begin
            cmd.div_step = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_HIGH;
         end
         mdps_pkg::S_LD_POW: begin
            cmd.div_load = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_POW;
         end
         mdps_pkg::S_DIV_POW: begin
            cmd.div_step = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_POW;
         end
         mdps_pkg::S_MUL: cmd.mul_red = 1'b1;
         mdps_pkg::S_LD_SUM: begin
            cmd.div_load = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_SUM;
         end
         mdps_pkg::S_DIV_SUM: begin
            cmd.div_step = 1'b1;
            cmd.div_opd  = mdps_pkg::OPD_SUM;
         end
         mdps_pkg::S_WAIT_OUT: cmd.load_out = !status.out_busy;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/mdps_datapath.sv =====
// Datapath of the modular dot product: multiplier, split accumulators,
// bit-serial remainder unit and result register. Depends on mdps_pkg.
`default_nettype none

module mdps_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mdps_pkg::cmd_type                   cmd,
   output mdps_pkg::status_type                     status,
   input  wire logic [mdps_pkg::ELEM_W-1:0]         a_elem,
   input  wire logic [mdps_pkg::ELEM_W-1:0]         b_elem,
   input  wire logic                                last_term,
   input  wire logic [mdps_pkg::ELEM_W-1:0]         modulus,
   input  wire logic [mdps_pkg::ELEM_W-1:0]         pow2_split_mod,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [mdps_pkg::ELEM_W-1:0]              dot_mod,
   output logic                                     too_long
);

   localparam int EW = mdps_pkg::ELEM_W;
   localparam int LW = mdps_pkg::LOW_W;
   localparam int HW = mdps_pkg::HIGH_W;
   localparam int PW = mdps_pkg::PROD_W;
   localparam int TW = mdps_pkg::TERM_W;
   localparam int GW = mdps_pkg::GROUP_W;
   localparam int CW = mdps_pkg::DIV_CNT_W;

   // Control state
   logic [LW-1:0] low_ff, low_in;
   logic [HW-1:0] high_ff, high_in;
   logic [GW-1:0] group_ff, group_in;
   logic [TW-1:0] term_ff, term_in;
   logic          ovf_ff, ovf_in;
   logic          last_ff, last_in;
   logic          out_valid_ff, out_valid_in;

   // Payload
   logic [PW-1:0] prod_ff, prod_in;
   logic [LW-1:0] shift_ff, shift_in;
   logic [EW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [EW-1:0] low_rem_ff, low_rem_in;
   logic [EW-1:0] high_rem_ff, high_rem_in;
   logic [EW-1:0] pow_rem_ff, pow_rem_in;
   logic [EW-1:0] sum_rem_ff, sum_rem_in;
   logic [EW-1:0] dot_ff, dot_in;
   logic          too_long_ff, too_long_in;

   logic [EW-1:0] mul_a, mul_b;
   logic [EW:0]   trial;
   logic [EW-1:0] rem_step;
   logic          div_last;

   // The single multiplier serves the input words and the final reduction.
   assign mul_a   = cmd.mul_red ? pow_rem_ff  : a_elem;
   assign mul_b   = cmd.mul_red ? high_rem_ff : b_elem;
   assign prod_in = (cmd.accept || cmd.mul_red) ? mul_a * mul_b : prod_ff;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign trial    = {rem_ff, shift_ff[LW-1]};
   assign rem_step = (trial >= {1'b0, modulus}) ? EW'(trial - {1'b0, modulus})
                                                : trial[EW-1:0];
   assign div_last = (cnt_ff == CW'(mdps_pkg::DIV_STEPS - 1));

   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      group_in     = group_ff;
      term_in      = term_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      low_rem_in   = low_rem_ff;
      high_rem_in  = high_rem_ff;
      pow_rem_in   = pow_rem_ff;
      sum_rem_in   = sum_rem_ff;
      dot_in       = dot_ff;
      too_long_in  = too_long_ff;

      if (cmd.accept) begin
         last_in = last_term;
      end

      if (cmd.acc) begin
         low_in   = low_ff + LW'(prod_ff);
         group_in = group_ff + GW'(1);
         if (term_ff >= TW'(mdps_pkg::MAX_TERMS)) begin
            ovf_in = 1'b1;
         end else begin
            term_in = term_ff + TW'(1);
         end
      end

      if (cmd.split) begin
         high_in = high_ff + HW'(low_ff >> mdps_pkg::SPLIT_BITS);
         low_in  = low_ff & mdps_pkg::LOW_MASK;
      end

      if (cmd.div_load) begin
         rem_in = '0;
         cnt_in = '0;
         case (cmd.div_opd)
            mdps_pkg::OPD_LOW:  shift_in = low_ff;
            mdps_pkg::OPD_HIGH: shift_in = LW'(high_ff);
            mdps_pkg::OPD_POW:  shift_in = LW'(pow2_split_mod);
            default:            shift_in = LW'(prod_ff) + LW'(low_rem_ff);
         endcase
      end

      if (cmd.div_step) begin
         rem_in   = rem_step;
         cnt_in   = cnt_ff + CW'(1);
         shift_in = shift_ff << 1;
         if (div_last) begin
            case (cmd.div_opd)
               mdps_pkg::OPD_LOW:  low_rem_in  = rem_step;
               mdps_pkg::OPD_HIGH: high_rem_in = rem_step;
               mdps_pkg::OPD_POW:  pow_rem_in  = rem_step;
               default:            sum_rem_in  = rem_step;
            endcase
         end
      end

      if (cmd.load_out) begin
         // A zero modulus yields zero by definition.
         dot_in       = (modulus == '0) ? '0 : sum_rem_ff;
         too_long_in  = ovf_ff;
         out_valid_in = 1'b1;
         low_in       = '0;
         high_in      = '0;
         group_in     = '0;
         term_in      = '0;
         ovf_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= '0;
         group_ff     <= '0;
         term_ff      <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         group_ff     <= group_in;
         term_ff      <= term_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      shift_ff    <= shift_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      low_rem_ff  <= low_rem_in;
      high_rem_ff <= high_rem_in;
      pow_rem_ff  <= pow_rem_in;
      sum_rem_ff  <= sum_rem_in;
      dot_ff      <= dot_in;
      too_long_ff <= too_long_in;
   end

   // The controller reads this in the accumulate cycle, before the group
   // counter advances, so the eighth term of a group shows a count of seven.
   assign status.split_due = (group_ff == '1) || last_ff;
   assign status.last      = last_ff;
   assign status.div_last  = div_last;
   assign status.out_busy  = out_valid_ff && !rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign dot_mod    = dot_ff;
   assign too_long   = too_long_ff;

endmodule

`default_nettype wire

// ===== rtl/core/modular_dot_product_split_top.sv =====
// Top level of the split-accumulation modular dot product.
// Holds the configuration registers; depends on mdps_pkg, mdps_ctrl, mdps_datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata a_elem, b_elem; tlast last_term
//   rsp      out        rsp_tvalid/rsp_tready  tdata dot_mod; tuser too_long
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A word that is not last is taken with its product registered, then accumulated,
// then split into the high accumulator when it closes a group of eight.
// The last word of a vector is followed by four remainders through the
// one-bit-per-cycle remainder unit and one reduced multiply.
// Reset is synchronous and clears all accumulators; csr writes are always taken.
// A stalled result holds in the output register; the next vector may stream
// in meanwhile, and only its own result waits for the register to free up.
`default_nettype none

module modular_dot_product_split_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [29:0] a_elem, [59:30] b_elem, [63:60] zero
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [29:0] dot_mod, [31:30] zero
   output logic             rsp_tuser,   // [0] too_long
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [29:0] csr_data
);

   localparam int EW = mdps_pkg::ELEM_W;

   logic [EW-1:0] modulus_ff, modulus_in;
   logic [EW-1:0] pow2_ff, pow2_in;
   logic [EW-1:0] dot_mod;

   mdps_pkg::cmd_type    cmd;
   mdps_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      modulus_in = modulus_ff;
      pow2_in    = pow2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mdps_pkg::CSR_MODULUS: modulus_in = csr_data;
            mdps_pkg::CSR_POW2:    pow2_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= EW'(2);
         pow2_ff    <= '0;
      end else begin
         modulus_ff <= modulus_in;
         pow2_ff    <= pow2_in;
      end
   end

   mdps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mdps_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .a_elem         (req_tdata[29:0]),
      .b_elem         (req_tdata[59:30]),
      .last_term      (req_tlast),
      .modulus        (modulus_ff),
      .pow2_split_mod (pow2_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .dot_mod        (dot_mod),
      .too_long       (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, dot_mod};

endmodule

`default_nettype wire

// ===== sim/modular_dot_product_split_top_tb.sv =====
// Self-checking testbench for modular_dot_product_split_top: streams element pairs with
// random idling, predicts each vector's reduced dot product and compares every result word.
// Depends on mdps_pkg and the RTL of the block only.
`default_nettype none

module modular_dot_product_split_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit [29:0] FIELD_MAX       = 30'h3FFF_FFFF;
   localparam int        DRAIN_CYCLES    = 300;
   localparam int        RSP_HOLD_CYCLES = 3000;
   localparam int        CYCLE_LIMIT     = 2_000_000;
   localparam int        RANDOM_PHASES   = 12;
   localparam int        ITEMS_PER_PHASE = 64;

   typedef struct {
      bit [29:0] dot;
      bit        too_long;
   } dot_result_type;

   // Tracks the running accumulation of the vector in flight and holds the
   // dot products that are still owed by the block.
   class modular_dot_tracker;
      bit [29:0]      modulus_reg;
      bit [29:0]      pow2_reg;
      bit [63:0]      low_sum;
      bit [39:0]      high_sum;
      bit [2:0]       group_fill;
      int             terms_seen;
      bit             too_many;
      dot_result_type awaited_dots[$];
      int             mismatches;

      function new();
         modulus_reg = 30'd2;
         pow2_reg    = 30'd0;
         mismatches  = 0;
         clear_vector();
      endfunction

      function void clear_vector();
         low_sum    = '0;
         high_sum   = '0;
         group_fill = '0;
         terms_seen = 0;
         too_many   = 1'b0;
      endfunction

      function void set_reg(logic idx, bit [29:0] value);
         if (idx == mdps_pkg::CSR_MODULUS)
            modulus_reg = value;
         else
            pow2_reg = value;
      endfunction

      function bit [29:0] reduce_sum();
         bit [63:0] n;
         bit [63:0] h;
         bit [63:0] p;
         bit [63:0] t;
         n = 64'(modulus_reg);
         if (n == 0)
            return '0;
         h = 64'(high_sum) % n;
         p = 64'(pow2_reg) % n;
         // Both factors are below 2^30, so the sum cannot wrap.
         t = p * h + (low_sum % n);
         return 30'(t % n);
      endfunction

      function void absorb_pair(bit [29:0] a, bit [29:0] b, bit last);
         dot_result_type res;
         low_sum = low_sum + 64'(a) * 64'(b);
         if (terms_seen >= mdps_pkg::MAX_TERMS)
            too_many = 1'b1;
         else
            terms_seen++;
         group_fill = group_fill + 3'd1;
         if (group_fill == 3'd0 || last) begin
            high_sum = high_sum + 40'(low_sum >> mdps_pkg::SPLIT_BITS);
            low_sum  = low_sum & mdps_pkg::LOW_MASK;
         end
         if (last) begin
            res.dot      = reduce_sum();
            res.too_long = too_many;
            awaited_dots.push_back(res);
            clear_vector();
         end
      endfunction

      function void check_dot(bit [29:0] dot, bit too_long);
         dot_result_type exp_res;
         if (awaited_dots.size() == 0) begin
            $display("%0t: unexpected result word, dot_mod %0d too_long %0d",
                     $time, dot, too_long);
            mismatches++;
            return;
         end
         exp_res = awaited_dots.pop_front();
         if (dot != exp_res.dot) begin
            $display("%0t: dot_mod mismatch, expected %0d, actual %0d",
                     $time, exp_res.dot, dot);
            mismatches++;
         end
         if (too_long != exp_res.too_long) begin
            $display("%0t: too_long mismatch, expected %0d, actual %0d",
                     $time, exp_res.too_long, too_long);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return awaited_dots.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [29:0] csr_data;

   modular_dot_tracker tracker;
   bit  steady_flow      = 1'b1;
   bit  rsp_hold_pending = 1'b0;
   int  cycle_count      = 0;

   modular_dot_product_split_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Both handshakes are sampled at the edge, before any update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.absorb_pair(req_tdata[29:0], req_tdata[59:30], req_tlast);
         if (rsp_tvalid && rsp_tready)
            tracker.check_dot(rsp_tdata[29:0], rsp_tuser);
      end
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: bursts of ready with random idle stretches, and one long hold-off on request.
   initial begin
      int idle;
      rsp_tready <= 1'b0;
      forever begin
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            if (!steady_flow) begin
               idle = idle_length();
               if (idle > 0) begin
                  rsp_tready <= 1'b0;
                  repeat (idle) @(posedge clock);
               end
            end
         end
      end
   end

   function automatic bit [29:0] split_power(bit [29:0] m);
      return 30'((64'd1 << mdps_pkg::SPLIT_BITS) % 64'(m));
   endfunction

   function automatic bit [29:0] pick_elem(bit [29:0] m);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return '0;
      else if (r < 16)
         return (m > 0) ? m - 30'd1 : '0;
      else if (r < 24)
         return FIELD_MAX;
      else if (r < 32 || m == 0)
         return 30'($urandom());
      return 30'($urandom_range(0, m - 30'd1));
   endfunction

   task automatic send_pair(bit [29:0] a, bit [29:0] b, bit last);
      int gap;
      gap = steady_flow ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, b, a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_vector(int len, bit [29:0] m);
      for (int i = 0; i < len; i++)
         send_pair(pick_elem(m), pick_elem(m), i == len - 1);
   endtask

   // The first edge lets the sampler note a word taken at the previous edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, bit [29:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, value);
   endtask

   task automatic apply_setting(bit [29:0] m, bit [29:0] p);
      write_reg(mdps_pkg::CSR_MODULUS, m);
      write_reg(mdps_pkg::CSR_POW2, p);
      csr_valid <= 1'b0;
   endtask

   initial begin
      bit [29:0] m;
      bit [29:0] p;
      int        sent;
      int        len;
      int        r;

      tracker = new();
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= mdps_pkg::CSR_MODULUS;
      csr_data   <= '0;
      reset      <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: a vector of length one under the reset settings.
      send_pair(30'd3, 30'd5, 1'b1);
      wait_drained();
      apply_setting(FIELD_MAX, split_power(FIELD_MAX));
      // Largest products over nine terms cross a group boundary; the elements
      // equal the modulus, so they are not below it.
      for (int i = 0; i < 9; i++)
         send_pair(FIELD_MAX, FIELD_MAX, i == 8);
      send_pair(30'd0, 30'd0, 1'b1);
      send_pair(30'd0, FIELD_MAX, 1'b0);
      send_pair(FIELD_MAX, 30'd0, 1'b0);
      send_pair(30'd1, 30'd1, 1'b1);
      // The group boundary and the last word fall together.
      for (int i = 0; i < 8; i++)
         send_pair(FIELD_MAX - 30'(i), 30'h2AAA_AAAA + 30'(i), i == 7);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         if ($urandom_range(0, 1) == 1)
            m = 30'($urandom_range(2, 1000));
         else
            m = 30'($urandom_range(2, FIELD_MAX));
         p = split_power(m);
         case (phase)
            0: begin
               m = 30'd2;
               p = split_power(m);
            end
            1: begin
               m = FIELD_MAX;
               p = split_power(m);
            end
            2: p = 30'($urandom());   // arbitrary, often not below the modulus
            3: m = 30'd0;
            4: begin
               m = 30'd1;
               p = FIELD_MAX;
            end
            6: p = 30'd0;
            default: ;
         endcase
         apply_setting(m, p);
         steady_flow = (phase % 4 == 3);
         // Hold the receiver while short vectors keep coming, so the input stalls.
         if (phase == 5)
            rsp_hold_pending = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (phase == 5)
               len = $urandom_range(1, 3);
            else if (r < 20)
               len = 1;
            else if (r < 80)
               len = $urandom_range(2, 12);
            else if (r < 95)
               len = $urandom_range(13, 40);
            else
               len = $urandom_range(41, 90);
            send_vector(len, m);
            sent += len;
         end
      end

      wait_drained();
      if (tracker.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
